// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the comment stripper.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define CCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// A condition at one edge that implies another at the next edge.
`define CCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/ccs_pkg.sv
// Types and constants of the comment stripper.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [3:0] {
      MODE_NORMAL     = 4'd0,
      MODE_HELD_SLASH = 4'd1,
      MODE_STRING     = 4'd2,
      MODE_STRING_ESC = 4'd3,
      MODE_CHAR       = 4'd4,
      MODE_CHAR_ESC   = 4'd5,
      MODE_LINE       = 4'd6,
      MODE_BLOCK      = 4'd7,
      MODE_BLOCK_STAR = 4'd8
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       stream_done;
   } rsp_type;

   // One queued word: when two_items is set a slash goes out ahead of data.
   typedef struct packed {
      logic       two_items;
      logic [7:0] data;
      logic       data_valid;
      logic       eos;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/ccs_queue.sv
// Short queue of classified words between the front and back parts.
// Depends on ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccs_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  ccs_pkg::entry_type    push_entry,
   input  wire                   pop,
   output ccs_pkg::entry_type    head_entry,
   output ccs_pkg::q_status_type status
);

   ccs_pkg::entry_type              mem_ff [ccs_pkg::QDEPTH];
   logic [ccs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ccs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ccs_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign status.full  = (count_ff == ccs_pkg::QCNT_W'(ccs_pkg::QDEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ccs_pkg::QPTR_W'(ccs_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ccs_pkg::QPTR_W'(ccs_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ccs_front.sv
// Front part: accepts source bytes, tracks the scan mode and classifies each byte.
// Depends on ccs_pkg; feeds ccs_queue.
`timescale 1ns / 1ps
`default_nettype none

module ccs_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  ccs_pkg::req_type       req,
   output logic                   push,
   output ccs_pkg::entry_type     push_entry,
   output ccs_pkg::scan_mode_type mode
);

   ccs_pkg::scan_mode_type mode_ff, mode_in;
   logic                   put_c, put_slash;
   logic [7:0]             c;
   logic                   last;

   assign c    = req.in_byte;
   assign last = req.end_of_stream;
   assign mode = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ccs_pkg::MODE_NORMAL;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      put_c     = 1'b0;
      put_slash = 1'b0;
      unique case (mode_ff) inside
         ccs_pkg::MODE_HELD_SLASH: begin
            if (c == ccs_pkg::CH_SLASH) begin
               mode_in = ccs_pkg::MODE_LINE;
            end else if (c == ccs_pkg::CH_STAR) begin
               mode_in = ccs_pkg::MODE_BLOCK;
            end else begin
               put_slash = 1'b1;
               put_c     = 1'b1;
               if (c == ccs_pkg::CH_DQUOTE) begin
                  mode_in = ccs_pkg::MODE_STRING;
               end else if (c == ccs_pkg::CH_SQUOTE) begin
                  mode_in = ccs_pkg::MODE_CHAR;
               end else begin
                  mode_in = ccs_pkg::MODE_NORMAL;
               end
            end
         end
         ccs_pkg::MODE_STRING: begin
            put_c = 1'b1;
            if (c == ccs_pkg::CH_BSLASH && !last) begin
               mode_in = ccs_pkg::MODE_STRING_ESC;
            end else if (c == ccs_pkg::CH_DQUOTE) begin
               mode_in = ccs_pkg::MODE_NORMAL;
            end
         end
         ccs_pkg::MODE_STRING_ESC: begin
            put_c   = 1'b1;
            mode_in = ccs_pkg::MODE_STRING;
         end
         ccs_pkg::MODE_CHAR: begin
            put_c = 1'b1;
            if (c == ccs_pkg::CH_BSLASH && !last) begin
               mode_in = ccs_pkg::MODE_CHAR_ESC;
            end else if (c == ccs_pkg::CH_SQUOTE) begin
               mode_in = ccs_pkg::MODE_NORMAL;
            end
         end
         ccs_pkg::MODE_CHAR_ESC: begin
            put_c   = 1'b1;
            mode_in = ccs_pkg::MODE_CHAR;
         end
         ccs_pkg::MODE_LINE: begin
            if (c == ccs_pkg::CH_NL) begin
               put_c   = 1'b1;
               mode_in = ccs_pkg::MODE_NORMAL;
            end
         end
         ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BLOCK_STAR: begin
            if (mode_ff == ccs_pkg::MODE_BLOCK_STAR && c == ccs_pkg::CH_SLASH) begin
               mode_in = ccs_pkg::MODE_NORMAL;
            end else if (c == ccs_pkg::CH_NL) begin
               put_c   = 1'b1;
               mode_in = ccs_pkg::MODE_BLOCK;
            end else if (c == ccs_pkg::CH_STAR && !last) begin
               mode_in = ccs_pkg::MODE_BLOCK_STAR;
            end else begin
               mode_in = ccs_pkg::MODE_BLOCK;
            end
         end
         default: begin
            if (c == ccs_pkg::CH_SLASH && !last) begin
               mode_in = ccs_pkg::MODE_HELD_SLASH;
            end else begin
               put_c = 1'b1;
               if (c == ccs_pkg::CH_DQUOTE) begin
                  mode_in = ccs_pkg::MODE_STRING;
               end else if (c == ccs_pkg::CH_SQUOTE) begin
                  mode_in = ccs_pkg::MODE_CHAR;
               end else begin
                  mode_in = ccs_pkg::MODE_NORMAL;
               end
            end
         end
      endcase
      if (last) begin
         mode_in = ccs_pkg::MODE_NORMAL;
      end
   end

   always_comb begin
      push_entry.two_items  = put_slash && put_c;
      push_entry.data       = put_c ? c : (put_slash ? ccs_pkg::CH_SLASH : 8'h00);
      push_entry.data_valid = put_c || put_slash;
      push_entry.eos        = last;
      push                  = accept && (put_c || put_slash || last);
   end

endmodule

`default_nettype wire

// File: hw/rtl/ccs_back.sv
// Back part: expands queued words into result words held in an output register.
// Depends on ccs_pkg; drains ccs_queue.
`timescale 1ns / 1ps
`default_nettype none

module ccs_back (
   input  wire                   clock,
   input  wire                   reset,
   input  ccs_pkg::entry_type    head_entry,
   input  ccs_pkg::q_status_type q_status,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output ccs_pkg::rsp_type      rsp_data,
   output logic                  phase
);

   ccs_pkg::rsp_type rsp_ff, rsp_in;
   logic             valid_ff, valid_in;
   logic             phase_ff, phase_in;
   logic             load;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;
   assign phase     = phase_ff;
   assign load      = !valid_ff || rsp_pop;

   always_comb begin
      rsp_in   = rsp_ff;
      valid_in = valid_ff;
      phase_in = phase_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (head_entry.two_items && !phase_ff) begin
               rsp_in.out_byte    = ccs_pkg::CH_SLASH;
               rsp_in.byte_valid  = 1'b1;
               rsp_in.last_of_run = 1'b0;
               rsp_in.stream_done = 1'b0;
               phase_in           = 1'b1;
            end else begin
               rsp_in.out_byte    = head_entry.data;
               rsp_in.byte_valid  = head_entry.data_valid;
               rsp_in.last_of_run = 1'b1;
               rsp_in.stream_done = head_entry.eos;
               phase_in           = 1'b0;
               q_pop              = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/c_comment_stripper_top.sv
// Top level of the C and C++ comment stripper: front classifier, queue, back expander.
// Depends on ccs_pkg, ccs_front, ccs_queue, ccs_back and assert_macros.svh.
//
// Source bytes go in one word per cycle while req_full is low, and stripped bytes come
// out one word per cycle while rsp_pop takes them; a byte's result word passes through
// the queue and then the back part's output register on its way to the result ports.
// A byte that follows a held slash yields two result words, the slash and then the byte,
// which the back part sends one after the other; the four-word queue absorbs the extra word.
// Bytes that are dropped produce no result word, and the final byte of a stream
// always ends in a word with stream_done set, a marker with byte_valid clear if
// that byte itself is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module c_comment_stripper_top (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   output logic             req_full,
   input  ccs_pkg::req_type req_data,
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output ccs_pkg::rsp_type rsp_data
);

   ccs_pkg::entry_type     push_entry, head_entry;
   ccs_pkg::q_status_type  q_status;
   ccs_pkg::scan_mode_type mode;
   logic                   accept, q_push, q_pop, phase;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   ccs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .push       (q_push),
      .push_entry (push_entry),
      .mode       (mode)
   );

   ccs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   ccs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .phase      (phase)
   );

   `CCS_ASSERT_NEXT(a_eos_to_normal, clock, reset, accept && req_data.end_of_stream, mode == ccs_pkg::MODE_NORMAL)
   `CCS_ASSERT(a_done_is_last, clock, reset, rsp_empty || !rsp_data.stream_done || rsp_data.last_of_run)
   `CCS_ASSERT(a_phase_has_pair, clock, reset, !phase || (!q_status.empty && head_entry.two_items))
   `CCS_ASSERT(a_marker_ends_stream, clock, reset, rsp_empty || rsp_data.byte_valid || rsp_data.stream_done)

endmodule

`default_nettype wire
